// ===== src/afmo_pkg.sv =====
// Shared types and constants of the arming/failsafe motor output block.
package afmo_pkg;

	typedef struct packed {
		logic [9:0] throttle;
		logic [9:0] yaw_stick;
		logic [9:0] pitch_stick;
		logic [9:0] roll_stick;
		logic [9:0] servo_stick;
		logic       link_ok;
		logic       kill_switch;
	} in_item_t;

	typedef struct packed {
		logic [11:0] motor_front_right;
		logic [11:0] motor_rear_right;
		logic [11:0] motor_rear_left;
		logic [11:0] motor_front_left;
		logic [11:0] trim_servo_down;
		logic [11:0] trim_servo_up;
		logic [11:0] direct_servo_up;
		logic [11:0] direct_servo_down;
		logic        link_led;
		logic [1:0]  mode;
	} out_item_t;

	typedef enum logic [1:0] {
		MODE_NORMAL = 2'd0,
		MODE_LINK   = 2'd1,
		MODE_KILL   = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		ARM_IDLE   = 2'd0,
		ARM_PRIMED = 2'd1,
		ARM_ARMED  = 2'd2
	} arm_step_t;

	// Configuration register indexes
	localparam logic [1:0] CFG_LOST_LIMIT = 2'd0;
	localparam logic [1:0] CFG_PULSE_MIN  = 2'd1;
	localparam logic [1:0] CFG_PULSE_MAX  = 2'd2;
	localparam logic [1:0] CFG_THR_CAP    = 2'd3;

	localparam logic [6:0]  LOST_LIMIT_RST = 7'd8;
	localparam logic [10:0] PULSE_MIN_RST  = 11'd1070;
	localparam logic [11:0] PULSE_MAX_RST  = 12'd2000;
	localparam logic [9:0]  THR_CAP_RST    = 10'd800;

	localparam logic [9:0]  STICK_LOW    = 10'd40;
	localparam logic [9:0]  YAW_ARM      = 10'd450;
	localparam logic [9:0]  YAW_DISARM   = 10'd950;
	localparam logic [9:0]  STICK_HIGH   = 10'd950;
	localparam logic [9:0]  STICK_BOTTOM = 10'd100;
	localparam logic [11:0] PULSE_IDLE   = 12'd1000;
	localparam logic [6:0]  LOST_SAT     = 7'd127;

	localparam logic signed [14:0] THRUST_MAX = 15'sd16383;
	localparam logic signed [14:0] THRUST_MIN = -15'sd16384;
	localparam logic signed [12:0] SERVO_TRIM_MAX = 13'sd2000;
	localparam logic signed [12:0] SERVO_TRIM_MIN = -13'sd500;
	localparam logic signed [12:0] SERVO_STEP = 13'sd2;

	// Reciprocal of ten, exact for 16-bit dividends with a shift of 19
	localparam logic [15:0] RECIP_TEN = 16'd52429;

	localparam logic [11:0] DIRECT_UP_BASE   = 12'd350;
	localparam logic [11:0] DIRECT_DOWN_BASE = 12'd2500;
	localparam logic signed [13:0] TRIM_DOWN_BASE = 14'sd2500;
	localparam logic signed [13:0] TRIM_UP_BASE   = 14'sd500;
	localparam logic signed [13:0] FRONT_BASE     = 14'sd1000;

endpackage

// ===== src/arming_failsafe_motor_output_core.sv =====
// Top level of the arming/failsafe motor output block.
//
// One radio frame comes in per transaction on the in_valid/in_ready channel and
// one result (eight pulse widths, link LED bit and mode code) leaves per
// transaction on the out_valid/out_ready channel, in frame order.
// A frame is captured into the input stage register, evaluated against the
// arming, lost-frame and lockout state, and written to the result register
// once that register is free or being taken; out_valid rises when the result
// register is loaded. One frame per cycle is sustained while the receiver
// keeps taking results: the only loop is the per-frame state update, a few
// compares and small adds.
// When the receiver stalls, the result register holds; one more frame can
// still be taken into the input stage, after which in_ready drops until the
// result is taken.
// Configuration registers are written through cfg_wr_en/cfg_index/cfg_data
// and should only change while no frame is in flight.
// Reset (arst_n low) restores register defaults, disarms, clears the trims,
// the lost-frame counter and both lockouts, and empties both stages.
module arming_failsafe_motor_output_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic [1:0]          cfg_index,
	input  logic [11:0]         cfg_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  afmo_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output afmo_pkg::out_item_t out_data
);
	import afmo_pkg::*;

	// Configuration registers
	logic [6:0]  lost_limit_q;
	logic [10:0] pulse_min_q;
	logic [11:0] pulse_max_q;
	logic [9:0]  thr_cap_q;

	// Per-frame state
	arm_step_t          arm_step_q, arm_step_d;
	logic [6:0]         lost_frames_q, lost_frames_d;
	logic               link_lock_q, link_lock_d;
	logic               kill_lock_q, kill_lock_d;
	logic signed [14:0] thrust_trim_q, thrust_trim_d;
	logic signed [11:0] servo_trim_q, servo_trim_d;

	// Pipeline
	logic      in_valid_s1;
	in_item_t  in_data_s1;
	logic      res_valid_s2;
	out_item_t res_data_s2;
	out_item_t res_d;
	logic      advance;

	// Frame evaluation intermediates
	logic               thr_low;
	logic               srv_low;
	logic               idle_out;
	logic               clear_run;
	logic               proceed;
	logic [6:0]         lost_inc;
	mode_t              mode_d;
	arm_step_t          arm_n;
	logic signed [14:0] trim_t;
	logic signed [11:0] trim_s;
	logic signed [12:0] servo_sum;
	logic               trim_neg;
	logic [15:0]        trim_mag;
	logic [31:0]        quot_prod;
	logic [10:0]        quot;
	logic signed [13:0] front_raw;
	logic signed [13:0] rear_raw;
	logic [9:0]         thr_capped;
	logic [11:0]        front_pw;
	logic [11:0]        rear_pw;

	// Clamp to the pulse window; the upper bound wins when the window is empty
	function automatic logic [11:0] clamp_pulse(
		input logic signed [13:0] p,
		input logic [10:0]        lo,
		input logic [11:0]        hi
	);
		logic signed [13:0] r;
		begin
			r = p;
			if (r < $signed({3'b000, lo})) begin
				r = $signed({3'b000, lo});
			end
			if (r > $signed({2'b00, hi})) begin
				r = $signed({2'b00, hi});
			end
			clamp_pulse = r[11:0];
		end
	endfunction

	// Handshake: advance the input stage when the result register is free
	assign advance   = in_valid_s1 && (!res_valid_s2 || out_ready);
	assign in_ready  = !in_valid_s1 || advance;
	assign out_valid = res_valid_s2;
	assign out_data  = res_data_s2;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lost_limit_q <= LOST_LIMIT_RST;
			pulse_min_q  <= PULSE_MIN_RST;
			pulse_max_q  <= PULSE_MAX_RST;
			thr_cap_q    <= THR_CAP_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_LOST_LIMIT: lost_limit_q <= cfg_data[6:0];
				CFG_PULSE_MIN:  pulse_min_q  <= cfg_data[10:0];
				CFG_PULSE_MAX:  pulse_max_q  <= cfg_data;
				CFG_THR_CAP:    thr_cap_q    <= cfg_data[9:0];
				default: ;
			endcase
		end
	end

	// Lockout handling, arming sequence and trim ramps for the frame in stage 1
	always_comb begin
		thr_low = in_data_s1.throttle < STICK_LOW;
		srv_low = in_data_s1.servo_stick < STICK_LOW;

		lost_frames_d = lost_frames_q;
		link_lock_d   = link_lock_q;
		kill_lock_d   = kill_lock_q;
		idle_out      = 1'b0;
		clear_run     = 1'b0;
		proceed       = 1'b1;
		mode_d        = MODE_NORMAL;
		lost_inc      = (lost_frames_q == LOST_SAT) ? LOST_SAT : lost_frames_q + 7'd1;

		if (kill_lock_q) begin
			if (thr_low && srv_low && !in_data_s1.kill_switch) begin
				// Release kill lockout and run the frame normally
				kill_lock_d = 1'b0;
				clear_run   = 1'b1;
			end else begin
				idle_out = 1'b1;
				mode_d   = MODE_KILL;
			end
		end else begin
			if (link_lock_q) begin
				if (thr_low && srv_low && in_data_s1.link_ok) begin
					link_lock_d   = 1'b0;
					clear_run     = 1'b1;
					lost_frames_d = '0;
				end else begin
					idle_out = 1'b1;
					mode_d   = MODE_LINK;
					proceed  = 1'b0;
				end
			end else if (!in_data_s1.link_ok) begin
				lost_frames_d = lost_inc;
				if (lost_inc > lost_limit_q) begin
					link_lock_d = 1'b1;
					idle_out    = 1'b1;
					mode_d      = MODE_LINK;
					proceed     = 1'b0;
				end
			end else begin
				lost_frames_d = '0;
			end
			if (proceed && in_data_s1.kill_switch) begin
				kill_lock_d = 1'b1;
				idle_out    = 1'b1;
				mode_d      = MODE_KILL;
			end
		end

		// Arming stages are tested in order on the same frame
		arm_n  = clear_run ? ARM_IDLE : arm_step_q;
		trim_t = clear_run ? '0 : thrust_trim_q;
		trim_s = clear_run ? '0 : servo_trim_q;
		if (arm_n == ARM_IDLE && thr_low && in_data_s1.yaw_stick < STICK_LOW) begin
			arm_n = ARM_PRIMED;
		end
		if (arm_n == ARM_PRIMED && thr_low && in_data_s1.yaw_stick > YAW_ARM) begin
			arm_n  = ARM_ARMED;
			trim_t = '0;
			trim_s = '0;
		end
		if (arm_n == ARM_ARMED && thr_low && in_data_s1.yaw_stick > YAW_DISARM) begin
			arm_n = ARM_IDLE;
		end

		if (arm_n == ARM_ARMED) begin
			if (in_data_s1.pitch_stick > STICK_HIGH && trim_t != THRUST_MAX) begin
				trim_t = trim_t + 15'sd1;
			end
			if (in_data_s1.pitch_stick < STICK_BOTTOM && trim_t != THRUST_MIN) begin
				trim_t = trim_t - 15'sd1;
			end
			if (in_data_s1.roll_stick > STICK_HIGH) begin
				servo_sum = 13'(trim_s) + SERVO_STEP;
				trim_s    = (servo_sum > SERVO_TRIM_MAX) ? 12'(SERVO_TRIM_MAX)
				                                         : servo_sum[11:0];
			end
			if (in_data_s1.roll_stick < STICK_BOTTOM) begin
				servo_sum = 13'(trim_s) - SERVO_STEP;
				trim_s    = (servo_sum < SERVO_TRIM_MIN) ? 12'(SERVO_TRIM_MIN)
				                                         : servo_sum[11:0];
			end
		end else begin
			trim_t = '0;
		end
		servo_sum = 13'(trim_s);

		// Front pulse: floor(trim / 10) through a reciprocal multiply on the magnitude
		trim_neg  = trim_t[14];
		trim_mag  = trim_neg ? (~16'({trim_t[14], trim_t}) + 16'd10)
		                     : {1'b0, trim_t};
		quot_prod = trim_mag * RECIP_TEN;
		quot      = quot_prod[29:19];
		front_raw = trim_neg ? (FRONT_BASE - $signed({3'b000, quot}))
		                     : (FRONT_BASE + $signed({3'b000, quot}));

		// Rear pulse follows the capped throttle
		thr_capped = (in_data_s1.throttle > thr_cap_q) ? thr_cap_q : in_data_s1.throttle;
		rear_raw   = FRONT_BASE + $signed({4'b0000, thr_capped});

		if (arm_n == ARM_ARMED) begin
			front_pw = clamp_pulse(front_raw, pulse_min_q, pulse_max_q);
			rear_pw  = clamp_pulse(rear_raw, pulse_min_q, pulse_max_q);
		end else begin
			front_pw = PULSE_IDLE;
			rear_pw  = PULSE_IDLE;
		end

		// Hold run state during a lockout frame; a link release that enters
		// kill lockout still drops it
		if (idle_out) begin
			arm_step_d    = clear_run ? ARM_IDLE : arm_step_q;
			thrust_trim_d = clear_run ? '0 : thrust_trim_q;
			servo_trim_d  = clear_run ? '0 : servo_trim_q;
		end else begin
			arm_step_d    = arm_n;
			thrust_trim_d = trim_t;
			servo_trim_d  = trim_s;
		end

		res_d.link_led = in_data_s1.link_ok;
		res_d.mode     = mode_d;
		if (idle_out) begin
			res_d.motor_front_right = PULSE_IDLE;
			res_d.motor_rear_right  = PULSE_IDLE;
			res_d.motor_rear_left   = PULSE_IDLE;
			res_d.motor_front_left  = PULSE_IDLE;
			res_d.trim_servo_down   = PULSE_IDLE;
			res_d.trim_servo_up     = PULSE_IDLE;
			res_d.direct_servo_up   = PULSE_IDLE;
			res_d.direct_servo_down = PULSE_IDLE;
		end else begin
			res_d.motor_front_right = front_pw;
			res_d.motor_rear_right  = rear_pw;
			res_d.motor_rear_left   = rear_pw;
			res_d.motor_front_left  = front_pw;
			res_d.trim_servo_down   = 12'(TRIM_DOWN_BASE - 14'(servo_sum));
			res_d.trim_servo_up     = 12'(TRIM_UP_BASE + 14'(servo_sum));
			res_d.direct_servo_up   = DIRECT_UP_BASE
			                          + 12'({in_data_s1.servo_stick, 1'b0});
			res_d.direct_servo_down = DIRECT_DOWN_BASE
			                          - 12'({in_data_s1.servo_stick, 1'b0});
		end
	end

	// Frame state advances once per evaluated frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arm_step_q    <= ARM_IDLE;
			lost_frames_q <= '0;
			link_lock_q   <= 1'b0;
			kill_lock_q   <= 1'b0;
			thrust_trim_q <= '0;
			servo_trim_q  <= '0;
		end else if (advance) begin
			arm_step_q    <= arm_step_d;
			lost_frames_q <= lost_frames_d;
			link_lock_q   <= link_lock_d;
			kill_lock_q   <= kill_lock_d;
			thrust_trim_q <= thrust_trim_d;
			servo_trim_q  <= servo_trim_d;
		end
	end

	// Stage valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1  <= 1'b0;
			res_valid_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				in_valid_s1 <= in_valid;
			end
			if (advance) begin
				res_valid_s2 <= 1'b1;
			end else if (out_ready) begin
				res_valid_s2 <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			in_data_s1 <= in_data;
		end
		if (advance) begin
			res_data_s2 <= res_d;
		end
	end

endmodule

// ===== src/afmo_checker.sv =====
// Port-level checker for the arming/failsafe motor output block, with its bind.
module afmo_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                out_valid,
	input logic                out_ready,
	input afmo_pkg::out_item_t out_data
);
	import afmo_pkg::*;

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// Lockout drives every compare output to idle
	a_lock_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.mode != MODE_NORMAL |->
		out_data.motor_front_right == PULSE_IDLE && out_data.motor_rear_right == PULSE_IDLE &&
		out_data.motor_rear_left == PULSE_IDLE && out_data.motor_front_left == PULSE_IDLE &&
		out_data.trim_servo_down == PULSE_IDLE && out_data.trim_servo_up == PULSE_IDLE &&
		out_data.direct_servo_up == PULSE_IDLE && out_data.direct_servo_down == PULSE_IDLE)
		else $error("lockout result not idle");

	// Mirrored motor pairs agree
	a_pairs: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.motor_front_right == out_data.motor_front_left &&
		out_data.motor_rear_right == out_data.motor_rear_left)
		else $error("motor pair mismatch");

	// Direct servo outputs are complementary in normal mode
	a_direct_sum: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.mode == MODE_NORMAL |->
		({1'b0, out_data.direct_servo_up} + {1'b0, out_data.direct_servo_down}) == 13'd2850)
		else $error("direct servo pair inconsistent");

endmodule

bind arming_failsafe_motor_output_core afmo_checker u_afmo_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

// ===== tb/sv/afmo_pulse_check.sv =====
// Transaction monitor and predictor for the arming/failsafe motor output block.
`timescale 1ns / 100ps

module afmo_pulse_check (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic [1:0]          cfg_index,
	input  logic [11:0]         cfg_data,
	input  logic                in_valid,
	input  logic                in_ready,
	input  afmo_pkg::in_item_t  in_data,
	input  logic                out_valid,
	input  logic                out_ready,
	input  afmo_pkg::out_item_t out_data,
	output int                  mismatches,
	output int                  backlog
);
	import afmo_pkg::*;

	localparam int LOW_STICK     = 40;
	localparam int ARM_YAW       = 450;
	localparam int DISARM_YAW    = 950;
	localparam int HIGH_STICK    = 950;
	localparam int BOTTOM_STICK  = 100;
	localparam int IDLE_PW       = 1000;
	localparam int TENTHS_TOP    = 16383;
	localparam int TENTHS_BOTTOM = -16384;
	localparam int SERVO_TOP     = 2000;
	localparam int SERVO_BOTTOM  = -500;
	localparam int SERVO_INC     = 2;
	localparam int LOST_CEIL     = 127;

	int lost_limit;
	int pulse_floor;
	int pulse_ceiling;
	int throttle_ceiling;

	arm_step_t arm_phase;
	int        lost_run;
	bit        link_locked;
	bit        kill_locked;
	int        thrust_tenths;
	int        servo_offset;

	out_item_t expected_pulses[$];

	initial mismatches = 0;

	task log_mismatch(input string msg);
		mismatches++;
		$display("%0t mismatch: %s", $time, msg);
	endtask

	task compare_field(input string name, input logic [11:0] got, input logic [11:0] want);
		if (got !== want)
			log_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
	endtask

	task drop_flight_state();
		arm_phase     = ARM_IDLE;
		thrust_tenths = 0;
		servo_offset  = 0;
	endtask

	function int bound_pulse(input int p);
		if (p < pulse_floor)
			p = pulse_floor;
		if (p > pulse_ceiling)
			p = pulse_ceiling;
		return p;
	endfunction

	task predict_pulses(input in_item_t f, output out_item_t r);
		int    thr, front, rear, trim_down, trim_up, dir_up, dir_down;
		bit    locked, thr_low;
		mode_t hold_mode;
		locked    = 1'b0;
		hold_mode = MODE_NORMAL;
		thr_low   = f.throttle < LOW_STICK;
		r         = '0;
		r.link_led = f.link_ok;

		// Lockout bookkeeping: a release frame clears the flight state and falls through
		if (kill_locked) begin
			if (thr_low && f.servo_stick < LOW_STICK && !f.kill_switch) begin
				kill_locked = 1'b0;
				drop_flight_state();
			end else begin
				locked    = 1'b1;
				hold_mode = MODE_KILL;
			end
		end else begin
			if (link_locked) begin
				if (thr_low && f.servo_stick < LOW_STICK && f.link_ok) begin
					link_locked = 1'b0;
					drop_flight_state();
					lost_run = 0;
				end else begin
					locked    = 1'b1;
					hold_mode = MODE_LINK;
				end
			end else if (!f.link_ok) begin
				if (lost_run < LOST_CEIL)
					lost_run++;
				if (lost_run > lost_limit) begin
					link_locked = 1'b1;
					locked      = 1'b1;
					hold_mode   = MODE_LINK;
				end
			end else begin
				lost_run = 0;
			end
			if (!locked && f.kill_switch) begin
				kill_locked = 1'b1;
				locked      = 1'b1;
				hold_mode   = MODE_KILL;
			end
		end

		if (locked) begin
			r.motor_front_right = 12'(IDLE_PW);
			r.motor_rear_right  = 12'(IDLE_PW);
			r.motor_rear_left   = 12'(IDLE_PW);
			r.motor_front_left  = 12'(IDLE_PW);
			r.trim_servo_down   = 12'(IDLE_PW);
			r.trim_servo_up     = 12'(IDLE_PW);
			r.direct_servo_up   = 12'(IDLE_PW);
			r.direct_servo_down = 12'(IDLE_PW);
			r.mode              = hold_mode;
		end else begin
			// Arming stages are evaluated in order on the same frame
			if (arm_phase == ARM_IDLE && thr_low && f.yaw_stick < LOW_STICK)
				arm_phase = ARM_PRIMED;
			if (arm_phase == ARM_PRIMED && thr_low && f.yaw_stick > ARM_YAW) begin
				arm_phase     = ARM_ARMED;
				thrust_tenths = 0;
				servo_offset  = 0;
			end
			if (arm_phase == ARM_ARMED && thr_low && f.yaw_stick > DISARM_YAW)
				arm_phase = ARM_IDLE;

			if (arm_phase == ARM_ARMED) begin
				if (f.pitch_stick > HIGH_STICK && thrust_tenths < TENTHS_TOP)
					thrust_tenths++;
				if (f.pitch_stick < BOTTOM_STICK && thrust_tenths > TENTHS_BOTTOM)
					thrust_tenths--;
				if (f.roll_stick > HIGH_STICK)
					servo_offset = (servo_offset + SERVO_INC > SERVO_TOP) ?
						SERVO_TOP : servo_offset + SERVO_INC;
				if (f.roll_stick < BOTTOM_STICK)
					servo_offset = (servo_offset - SERVO_INC < SERVO_BOTTOM) ?
						SERVO_BOTTOM : servo_offset - SERVO_INC;
				// Floor division of the tenths
				front = IDLE_PW + ((thrust_tenths >= 0) ? thrust_tenths / 10 :
					-((-thrust_tenths + 9) / 10));
				thr = int'(f.throttle);
				if (thr > throttle_ceiling)
					thr = throttle_ceiling;
				rear  = bound_pulse(IDLE_PW + thr);
				front = bound_pulse(front);
			end else begin
				thrust_tenths = 0;
				front = IDLE_PW;
				rear  = IDLE_PW;
			end
			trim_down = 2500 - servo_offset;
			trim_up   = 500 + servo_offset;
			dir_up    = 350 + 2 * int'(f.servo_stick);
			dir_down  = 2500 - 2 * int'(f.servo_stick);
			r.motor_front_right = front[11:0];
			r.motor_rear_right  = rear[11:0];
			r.motor_rear_left   = rear[11:0];
			r.motor_front_left  = front[11:0];
			r.trim_servo_down   = trim_down[11:0];
			r.trim_servo_up     = trim_up[11:0];
			r.direct_servo_up   = dir_up[11:0];
			r.direct_servo_down = dir_down[11:0];
			r.mode              = MODE_NORMAL;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		out_item_t want;
		if (!arst_n) begin
			lost_limit       = 8;
			pulse_floor      = 1070;
			pulse_ceiling    = 2000;
			throttle_ceiling = 800;
			lost_run         = 0;
			link_locked      = 1'b0;
			kill_locked      = 1'b0;
			drop_flight_state();
			expected_pulses.delete();
			backlog = 0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					CFG_LOST_LIMIT: lost_limit       = int'(cfg_data[6:0]);
					CFG_PULSE_MIN:  pulse_floor      = int'(cfg_data[10:0]);
					CFG_PULSE_MAX:  pulse_ceiling    = int'(cfg_data);
					CFG_THR_CAP:    throttle_ceiling = int'(cfg_data[9:0]);
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (expected_pulses.size() == 0) begin
					log_mismatch("result with no frame outstanding");
				end else begin
					want = expected_pulses.pop_front();
					compare_field("motor_front_right", out_data.motor_front_right,
						want.motor_front_right);
					compare_field("motor_rear_right", out_data.motor_rear_right,
						want.motor_rear_right);
					compare_field("motor_rear_left", out_data.motor_rear_left,
						want.motor_rear_left);
					compare_field("motor_front_left", out_data.motor_front_left,
						want.motor_front_left);
					compare_field("trim_servo_down", out_data.trim_servo_down,
						want.trim_servo_down);
					compare_field("trim_servo_up", out_data.trim_servo_up,
						want.trim_servo_up);
					compare_field("direct_servo_up", out_data.direct_servo_up,
						want.direct_servo_up);
					compare_field("direct_servo_down", out_data.direct_servo_down,
						want.direct_servo_down);
					compare_field("link_led", 12'(out_data.link_led), 12'(want.link_led));
					compare_field("mode", 12'(out_data.mode), 12'(want.mode));
				end
			end
			if (in_valid && in_ready) begin
				predict_pulses(in_data, want);
				expected_pulses.push_back(want);
			end
			backlog = expected_pulses.size();
		end
	end

endmodule

// ===== tb/sv/tb.sv =====
// Top of the testbench for the arming/failsafe motor output core.
`timescale 1ns / 100ps

module tb;
	import afmo_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [1:0]  cfg_index;
	logic [11:0] cfg_data;
	logic        in_valid;
	logic        in_ready;
	in_item_t    in_data;
	logic        out_valid;
	logic        out_ready = 1'b0;
	out_item_t   out_data;

	int mismatches;
	int backlog;

	// Traffic shaping, set by the stimulus process
	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	int          lost_limit_now = 8;

	// Handshake counters, advanced at the rising edge
	int unsigned frames_in   = 0;
	int unsigned results_out = 0;

	// Receiver hold-off bookkeeping
	int unsigned hold_left = 0;
	int unsigned next_hold = 100;

	always #6 clk = ~clk;

	arming_failsafe_motor_output_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	afmo_pulse_check pulse_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data),
		.mismatches (mismatches),
		.backlog    (backlog)
	);

	always @(posedge clk) begin
		if (in_valid && in_ready)
			frames_in <= frames_in + 1;
		if (out_valid && out_ready)
			results_out <= results_out + 1;
	end

	// Receiver: random stalls, plus a long hold-off every 800 results so the
	// input stage fills and in_ready drops while frames keep coming
	always @(negedge clk) begin
		if (hold_left != 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (results_out >= next_hold) begin
			out_ready <= 1'b0;
			hold_left <= 60;
			next_hold <= next_hold + 800;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Random single bit
	function automatic bit coin();
		return 1'($urandom_range(1));
	endfunction

	// Offer one frame; return at the falling edge after it is accepted,
	// with valid still high so back-to-back frames need no extra step
	task automatic send_sticks(input int thr, yaw, pitch, roll, srv, input bit link, kill);
		in_item_t    f;
		int unsigned goal;
		f.throttle    = 10'(thr);
		f.yaw_stick   = 10'(yaw);
		f.pitch_stick = 10'(pitch);
		f.roll_stick  = 10'(roll);
		f.servo_stick = 10'(srv);
		f.link_ok     = link;
		f.kill_switch = kill;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= f;
		goal = frames_in + 1;
		do @(negedge clk); while (frames_in != goal);
	endtask

	// Drain, let the pipeline settle, then write all four registers
	task automatic set_regs(input int lim, pmin, pmax, cap);
		in_valid <= 1'b0;
		do @(negedge clk); while (backlog != 0);
		repeat (4) @(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= CFG_LOST_LIMIT;
		cfg_data  <= 12'(lim);
		@(negedge clk);
		cfg_index <= CFG_PULSE_MIN;
		cfg_data  <= 12'(pmin);
		@(negedge clk);
		cfg_index <= CFG_PULSE_MAX;
		cfg_data  <= 12'(pmax);
		@(negedge clk);
		cfg_index <= CFG_THR_CAP;
		cfg_data  <= 12'(cap);
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		lost_limit_now = lim;
	endtask

	// Pitch/roll value leaning high (0), low (1) or anywhere (2)
	function automatic int trim_stick(input int lean);
		int r;
		r = $urandom_range(99);
		if (lean == 2 || r >= 80)
			return $urandom_range(1023);
		if (r >= 70)
			return lean ? 100 : 950;
		return lean ? $urandom_range(99) : $urandom_range(1023, 951);
	endfunction

	// Mixed traffic until the accepted-frame count reaches goal
	task automatic run_traffic(input int unsigned goal);
		int pick, n, lean_p, lean_r;
		while (frames_in < goal) begin
			pick = $urandom_range(99);
			if (pick < 45) begin
				// Arm, fly with drifting trims, maybe disarm
				send_sticks($urandom_range(39), $urandom_range(39), $urandom_range(1023),
					$urandom_range(1023), $urandom_range(1023), 1'b1, 1'b0);
				send_sticks($urandom_range(39),
					($urandom_range(9) == 0) ? $urandom_range(1023, 951) :
					$urandom_range(950, 451),
					$urandom_range(1023), $urandom_range(1023), $urandom_range(1023),
					1'b1, 1'b0);
				lean_p = $urandom_range(2);
				lean_r = $urandom_range(2);
				n = $urandom_range(60, 5);
				repeat (n)
					send_sticks(($urandom_range(19) == 0) ? $urandom_range(39) :
						$urandom_range(1023, 40), $urandom_range(1023),
						trim_stick(lean_p), trim_stick(lean_r), $urandom_range(1023),
						$urandom_range(24) != 0, 1'b0);
				if (coin())
					send_sticks($urandom_range(39), $urandom_range(1023, 951),
						$urandom_range(1023), $urandom_range(1023), $urandom_range(1023),
						1'b1, 1'b0);
			end else if (pick < 60) begin
				// Lost frames around the limit, failed releases, then a release
				n = $urandom_range(lost_limit_now + 3, 1);
				repeat (n)
					send_sticks($urandom_range(1023), $urandom_range(1023),
						$urandom_range(1023), $urandom_range(1023), $urandom_range(1023),
						1'b0, 1'b0);
				repeat ($urandom_range(2))
					send_sticks($urandom_range(1023), $urandom_range(1023),
						$urandom_range(1023), $urandom_range(1023), $urandom_range(1023),
						coin(), 1'b0);
				send_sticks($urandom_range(39), $urandom_range(1023), $urandom_range(1023),
					$urandom_range(1023), $urandom_range(39), 1'b1, 1'b0);
			end else if (pick < 75) begin
				// Kill, some frames inside the lockout, then a release
				send_sticks($urandom_range(1023), $urandom_range(1023), $urandom_range(1023),
					$urandom_range(1023), $urandom_range(1023), coin(), 1'b1);
				repeat ($urandom_range(3))
					send_sticks($urandom_range(1023), $urandom_range(1023),
						$urandom_range(1023), $urandom_range(1023), $urandom_range(1023),
						coin(), coin());
				send_sticks($urandom_range(39), $urandom_range(1023), $urandom_range(1023),
					$urandom_range(1023), $urandom_range(39), coin(), 1'b0);
			end else begin
				// Noise
				repeat ($urandom_range(4, 1))
					send_sticks($urandom_range(1023), $urandom_range(1023),
						$urandom_range(1023), $urandom_range(1023), $urandom_range(1023),
						coin(), coin());
			end
		end
	endtask

	initial begin
		int k;
		arst_n    = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = CFG_LOST_LIMIT;
		cfg_data  = '0;
		in_valid  = 1'b0;
		in_data   = '0;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed frames under reset settings
		send_sticks(0, 0, 512, 512, 0, 1'b1, 1'b0);          // prime
		send_sticks(0, 1023, 512, 512, 0, 1'b1, 1'b0);       // arm and disarm at once
		send_sticks(39, 39, 512, 512, 39, 1'b1, 1'b0);       // prime at the low edge
		send_sticks(39, 451, 1023, 1023, 1023, 1'b1, 1'b0);  // arm, trims up
		send_sticks(1023, 0, 0, 0, 0, 1'b1, 1'b0);           // throttle over cap, trims down
		send_sticks(40, 1023, 951, 99, 512, 1'b1, 1'b0);     // throttle not low: stay armed
		send_sticks(801, 500, 950, 100, 700, 1'b1, 1'b0);    // trim thresholds, no step
		send_sticks(0, 951, 512, 512, 512, 1'b1, 1'b0);      // disarm
		send_sticks(500, 500, 1023, 1023, 0, 1'b1, 1'b0);    // disarmed: thrust trim cleared
		send_sticks(0, 0, 0, 0, 0, 1'b1, 1'b1);              // kill lockout
		send_sticks(0, 0, 0, 0, 40, 1'b1, 1'b0);             // servo not low: hold
		send_sticks(0, 0, 0, 0, 0, 1'b0, 1'b0);              // release, lost frame not counted
		repeat (9)
			send_sticks(300, 300, 300, 300, 300, 1'b0, 1'b0);  // link lockout on the ninth
		send_sticks(0, 0, 0, 0, 0, 1'b1, 1'b1);              // link release into kill lockout
		send_sticks(0, 0, 0, 0, 0, 1'b0, 1'b0);              // kill release

		// Random traffic: three idle regimes, three register settings each
		for (k = 0; k < 9; k++) begin
			case (k / 3)
				0: begin send_idle_pct = 9;  recv_idle_pct = 73; end
				1: begin send_idle_pct = 73; recv_idle_pct = 9;  end
				default: begin send_idle_pct = 0; recv_idle_pct = 0; end
			endcase
			case (k)
				0: set_regs(0, 1000, 2500, 1023);
				1: set_regs(126, 2000, 1000, 0);
				3: set_regs(127, 1070, 2000, 800);
				4: set_regs(8, 1070, 2000, 800);
				6: set_regs(1, 1500, 1600, 1023);
				8: set_regs(8, 1070, 2000, 800);
				default: set_regs($urandom_range(12), $urandom_range(1200, 1000),
					$urandom_range(2500, 1800), $urandom_range(1023));
			endcase
			run_traffic(frames_in + 100);
		end

		// Long armed runs drive the servo trim toward both limits, wide pulse window
		set_regs(8, 0, 4095, 800);
		send_sticks(0, 0, 512, 512, 512, 1'b1, 1'b0);
		send_sticks(0, 600, 512, 512, 512, 1'b1, 1'b0);
		repeat (260)
			send_sticks($urandom_range(1023, 40), $urandom_range(1023),
				$urandom_range(1023, 951), $urandom_range(1023, 951),
				$urandom_range(1023), 1'b1, 1'b0);
		send_sticks(0, 1023, 512, 512, 512, 1'b1, 1'b0);
		send_sticks(0, 0, 512, 512, 512, 1'b1, 1'b0);
		send_sticks(0, 600, 512, 512, 512, 1'b1, 1'b0);
		repeat (260)
			send_sticks($urandom_range(1023, 40), $urandom_range(1023),
				$urandom_range(99), $urandom_range(99), $urandom_range(1023), 1'b1, 1'b0);

		// Drain and give the verdict
		in_valid <= 1'b0;
		do @(negedge clk); while (backlog != 0);
		repeat (10) @(negedge clk);
		if (mismatches == 0 && backlog == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// Watchdog
	initial begin
		#1_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
